[hdl/assert_macros.svh]
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge, off while reset is applied.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must hold at every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/oakv_pkg.sv]
`timescale 1ns / 1ps
package oakv_pkg;

  localparam int unsigned LOG2_SLOTS = 8;
  localparam int unsigned KEY_BITS = 32;
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned SLOT_DEPTH = 1 << LOG2_SLOTS;
  localparam int unsigned SLOT_W = LOG2_SLOTS;
  localparam int unsigned COUNT_W = LOG2_SLOTS + 1;
  localparam int unsigned ENTRY_W = KEY_BITS + VALUE_BITS;
  localparam int unsigned FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    REQ_GET    = 2'd0,
    REQ_UPDATE = 2'd1,
    REQ_PUT    = 2'd2,
    REQ_NOP    = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_UNUSED    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] key_handle;
    logic [31:0] key_hash;
    logic [63:0] write_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [8:0]  entry_count;
  } rsp_t;

  // Classified request handed from the front part to the probe engine.
  typedef struct packed {
    logic              active;
    logic              is_get;
    logic              is_put;
    logic [KEY_BITS-1:0]   key;
    logic [31:0]       hash;
    logic [VALUE_BITS-1:0] wval;
    logic [3:0]        log2;
  } job_t;

  function automatic logic [3:0] clamp_size(input logic [3:0] s);
    logic [3:0] r;
    r = s;
    if (s < 4'd2) r = 4'd2;
    if (s > 4'(LOG2_SLOTS)) r = 4'(LOG2_SLOTS);
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] size_mask(input logic [3:0] log2);
    logic [SLOT_DEPTH:0] full;
    full = ({{SLOT_DEPTH{1'b0}}, 1'b1} << log2) - 1'b1;
    return full[SLOT_W-1:0];
  endfunction

endpackage

[hdl/oakv_ram.sv]
`timescale 1ns / 1ps
module oakv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/oakv_front.sv]
`timescale 1ns / 1ps
module oakv_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  oakv_pkg::req_t  req_i,
  input  logic [3:0]      size_i,
  output logic            job_valid_o,
  input  logic            job_ready_i,
  output oakv_pkg::job_t  job_o
);
  import oakv_pkg::*;

  `include "assert_macros.svh"

  job_t        fifo_q [FIFO_DEPTH];
  logic [0:0]  wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  job_t        job_in;
  logic        push, pop;

  always_comb begin
    job_in.active = (req_i.req_type != REQ_NOP);
    job_in.is_get = (req_i.req_type == REQ_GET);
    job_in.is_put = (req_i.req_type == REQ_PUT);
    job_in.key    = req_i.key_handle[KEY_BITS-1:0];
    job_in.hash   = req_i.key_hash;
    job_in.wval   = req_i.write_value[VALUE_BITS-1:0];
    job_in.log2   = clamp_size(size_i);
  end

  assign req_ready_o = (cnt_q != 2'(FIFO_DEPTH));
  assign push        = req_valid_i && req_ready_o;
  assign job_valid_o = (cnt_q != 2'd0);
  assign pop         = job_valid_o && job_ready_i;
  assign job_o       = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= job_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

  `ASSERT_CLK(a_fifo_bound, clk_i, rst_ni, cnt_q <= 2'(FIFO_DEPTH), "queue overflow")
  `ASSERT_CLK(a_fifo_ptrs, clk_i, rst_ni,
    (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q), "queue pointers disagree with count")

endmodule

[hdl/oakv_back.sv]
`timescale 1ns / 1ps
module oakv_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  output logic            job_ready_o,
  input  oakv_pkg::job_t  job_i,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output oakv_pkg::rsp_t  rsp_o,
  output logic            busy_o
);
  import oakv_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_RESP  = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic [SLOT_DEPTH-1:0] valid_q;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [31:0]         hash_q, hash_d;
  logic [COUNT_W:0]    probes_q, probes_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  job_t                job_q;
  rsp_t                rsp_q, rsp_d;
  logic                rsp_valid_q, rsp_valid_d;

  logic                we;
  logic [SLOT_W-1:0]   waddr;
  logic [ENTRY_W-1:0]  wdata, rdata;
  logic                valid_set;
  logic [SLOT_W-1:0]   mask;
  logic [COUNT_W:0]    limit;
  logic [COUNT_W+1:0]  cap3;
  logic [31:0]         hash_sh;
  logic [SLOT_W+2:0]   next_slot;
  logic                hit;

  oakv_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (slot_q),
    .rdata_o (rdata)
  );

  assign mask    = size_mask(job_q.log2);
  assign limit   = (COUNT_W+1)'(({{COUNT_W{1'b0}}, 1'b1} << job_q.log2) + 8);
  assign cap3    = (COUNT_W+2)'((({{COUNT_W{1'b0}}, 1'b1} << job_q.log2) * 3) >> 2);
  assign hash_sh = hash_q >> 5;
  assign next_slot = (SLOT_W+3)'(slot_q) * (SLOT_W+3)'(5) + (SLOT_W+3)'(1)
                   + (SLOT_W+3)'(hash_sh[SLOT_W-1:0]);
  assign hit     = (rdata[ENTRY_W-1 -: KEY_BITS] == job_q.key);

  assign job_ready_o = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;
  assign busy_o      = (state_q != S_IDLE) || rsp_valid_q;

  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    hash_d      = hash_q;
    probes_d    = probes_q;
    count_d     = count_q;
    rsp_d       = rsp_q;
    rsp_valid_d = rsp_valid_q;
    we          = 1'b0;
    waddr       = slot_q;
    wdata       = {job_q.key, job_q.wval};
    valid_set   = 1'b0;
    if (rsp_valid_q && rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (job_valid_i && job_ready_o) begin
          slot_d   = job_i.hash[SLOT_W-1:0] & size_mask(job_i.log2);
          hash_d   = job_i.hash;
          probes_d = '0;
          rsp_d.status      = ST_OK;
          rsp_d.read_value  = '0;
          rsp_d.entry_count = count_q;
          state_d  = job_i.active ? S_READ : S_RESP;
        end
      end
      S_CLEAR: state_d = S_IDLE;
      S_READ: begin
        if (probes_q >= limit) begin
          rsp_d.status = job_q.is_put ? ST_FULL : ST_NOT_FOUND;
          state_d = S_RESP;
        end else if (!valid_q[slot_q]) begin
          if (!job_q.is_put) begin
            rsp_d.status = ST_NOT_FOUND;
          end else if ((COUNT_W+2)'(count_q) >= cap3) begin
            rsp_d.status = ST_FULL;
          end else begin
            we        = 1'b1;
            valid_set = 1'b1;
            count_d   = count_q + 1'b1;
            rsp_d.entry_count = count_q + 1'b1;
          end
          state_d = S_RESP;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (hit) begin
          if (job_q.is_get) begin
            rsp_d.read_value = 64'(rdata[VALUE_BITS-1:0]);
          end else begin
            we = 1'b1;
          end
          state_d = S_RESP;
        end else begin
          hash_d   = hash_sh;
          slot_d   = next_slot[SLOT_W-1:0] & mask;
          probes_d = probes_q + 1'b1;
          state_d  = S_READ;
        end
      end
      S_RESP: begin
        rsp_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (job_valid_i && job_ready_o) begin
      job_q <= job_i;
    end
    slot_q <= slot_d;
    hash_q <= hash_d;
    probes_q <= probes_d;
    rsp_q  <= rsp_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      valid_q     <= '0;
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (valid_set) valid_q[slot_q] <= 1'b1;
    end
  end

  `ASSERT_CLK(a_onehot, clk_i, rst_ni, $onehot(state_q), "state not one-hot")
  `ASSERT_CLK(a_count_step, clk_i, rst_ni,
    (count_q == $past(count_q)) || (count_q == $past(count_q) + 1'b1),
    "entry count moved by more than one")
  `ASSERT_CLK(a_rsp_hold, clk_i, rst_ni,
    (rsp_valid_q && !rsp_ready_i) |=> (rsp_valid_q && $stable(rsp_q)),
    "response changed while stalled")
  `ASSERT_CLK(a_count_bound, clk_i, rst_ni, count_q <= COUNT_W'(SLOT_DEPTH),
    "entry count beyond capacity")

endmodule

[hdl/open_addressing_key_value_table.sv]
`timescale 1ns / 1ps
// Open-addressing key/value table: a request (get, update or put) enters a two-entry queue,
// then the probe engine walks the probe path with one table read per probe. The engine takes
// a request in its idle state, passes through a read and a check state on every probe that
// reads an occupied slot, through the read state alone on a probe that ends at a free slot,
// and through a response state, after which the response appears on the following cycle.
// The engine takes its next request only on the cycle after the response is accepted, and a
// request of type three goes from the idle state straight to the response state; the number
// of probes depends on the keys already stored. The slot array is empty after reset through
// per-slot valid bits. Write the size register only while no transaction is in flight.
module open_addressing_key_value_table (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [3:0]     cfg_data_i,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  oakv_pkg::req_t req_i,
  output logic           rsp_valid_o,
  input  logic           rsp_ready_i,
  output oakv_pkg::rsp_t rsp_o
);
  import oakv_pkg::*;

  logic [3:0] size_q;
  logic       job_valid, job_ready, busy;
  job_t       job;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= 4'd8;
    end else if (cfg_valid_i) begin
      size_q <= cfg_data_i;
    end
  end

  oakv_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_i       (req_i),
    .size_i      (size_q),
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  oakv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .rsp_o       (rsp_o),
    .busy_o      (busy)
  );

  `include "assert_macros.svh"

  `ASSERT_CLK(a_idle_no_rsp, clk_i, rst_ni, !busy |-> !rsp_valid_o, "response while idle")

endmodule
